FILE: rtl/core/tsa_pkg.sv
// ----------------------------------------------------------------------------
// tsa_pkg
// Shared widths and defaults for the scaled tanh activation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package tsa_pkg;

  localparam int X_W = 16;
  localparam int Y_W = 16;
  localparam int DEF_TABLE_SEGMENTS = 64;
  localparam int DEF_INPUT_FRAC_BITS = 12;
  localparam int PIPE_DEPTH = 6;
  localparam logic [Y_W-1:0] Y_HALF = 16'd32768;
  localparam logic [Y_W-1:0] Y_MAX = 16'd65535;

endpackage

`default_nettype wire

FILE: rtl/core/tanh_sigmoid_activation.sv
// ----------------------------------------------------------------------------
// tanh_sigmoid_activation
// Scaled tanh activation (tanh(x)+1)/2 and derivative (1-tanh(x)^2)/2,
// piecewise-linear table interpolation, one request per clock.
// ----------------------------------------------------------------------------
// A request (in_cmd, in_x_in) is taken on every clock edge with start high;
// busy is always low. The result appears on out_y_out with out_valid high for
// exactly one cycle, in request order. The six register stages are: magnitude,
// table lookup, slope multiply, interpolation, square, final select/saturate.
// The receiver cannot stall the pipeline.
`default_nettype none

module tanh_sigmoid_activation #(
  parameter int TABLE_SEGMENTS = tsa_pkg::DEF_TABLE_SEGMENTS,
  parameter int INPUT_FRAC_BITS = tsa_pkg::DEF_INPUT_FRAC_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic                  in_cmd,
  input  wire logic [tsa_pkg::X_W-1:0] in_x_in,
  output logic                       out_valid,
  output logic [tsa_pkg::Y_W-1:0]    out_y_out
);
  import tsa_pkg::*;

  localparam int KW = $clog2(TABLE_SEGMENTS + 1);
  localparam int ShW = INPUT_FRAC_BITS + 3;
  localparam int PosW = ((X_W > ShW) ? X_W : ShW) + KW;
  localparam int TW = 17;
  localparam int PW = TW + ShW;
  localparam logic [PosW-1:0] Range = PosW'(1) << ShW;
  localparam logic [PW:0] HalfRange = (PW+1)'(1) << (ShW - 1);
  localparam logic [TW-1:0] OneQ16 = 17'h1_0000;

  // long division for the elaboration-time table build
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], n[b]};
      if (rem >= {1'b0, d}) begin
        rem = rem - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-16k/S) in Q0.32, evaluated at elaboration only
  function automatic logic [63:0] exp_neg(input int unsigned k);
    logic [63:0] g;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] u;
    g = udiv64(64'(k) << 31, 64'(TABLE_SEGMENTS));
    term = 64'h1_0000_0000;
    sum = term;
    for (int i = 1; i <= 24; i++) begin
      term = udiv64((term * g) >> 32, 64'(i));
      sum = sum + term;
    end
    u = udiv64(64'hFFFF_FFFF_FFFF_FFFF, sum);
    for (int j = 0; j < 5; j++) begin
      u = (u * u) >> 32;
    end
    return u;
  endfunction

  function automatic logic [TW-1:0] tanh_entry(input int unsigned k);
    logic [63:0] u;
    logic [63:0] num;
    logic [63:0] den;
    u = exp_neg(k);
    num = (64'h1_0000_0000 - u) << 16;
    den = 64'h1_0000_0000 + u;
    return TW'(udiv64(num + (den >> 1), den));
  endfunction

  logic [TW-1:0] rom [TABLE_SEGMENTS+1];

  for (genvar gi = 0; gi <= TABLE_SEGMENTS; gi++) begin : g_rom
    localparam logic [TW-1:0] Entry = tanh_entry(gi);
    assign rom[gi] = Entry;
  end

  assign busy = 1'b0;

  // stage 1: magnitude
  logic            v1_r, cmd1_r, neg1_r;
  logic [X_W-1:0]  mag1_r;
  logic [X_W-1:0]  mag_nxt;

  assign mag_nxt = in_x_in[X_W-1] ? (X_W'(0) - in_x_in) : in_x_in;

  // stage 2: segment lookup
  logic            v2_r, cmd2_r, neg2_r, sat2_r;
  logic [TW-1:0]   lo2_r, hi2_r;
  logic [ShW-1:0]  r2_r;
  logic [PosW-1:0] pos_nxt;
  logic [KW-1:0]   k_nxt;
  logic [KW-1:0]   k_hi_nxt;

  assign pos_nxt = PosW'(mag1_r) * PosW'(TABLE_SEGMENTS);
  assign k_nxt = pos_nxt[ShW +: KW];
  // clamp input lands on the last entry
  assign k_hi_nxt = (k_nxt >= KW'(TABLE_SEGMENTS)) ? k_nxt : (k_nxt + KW'(1));

  // stage 3: slope times remainder
  logic            v3_r, cmd3_r, neg3_r, sat3_r;
  logic [TW-1:0]   lo3_r;
  logic [PW-1:0]   prod3_r;
  logic [TW-1:0]   diff_nxt;

  assign diff_nxt = (hi2_r >= lo2_r) ? (hi2_r - lo2_r) : '0;

  // stage 4: interpolated tanh magnitude
  logic            v4_r, cmd4_r, neg4_r;
  logic [TW-1:0]   th4_r;
  logic [PW:0]     rnd_nxt;
  logic [TW-1:0]   th_nxt;

  assign rnd_nxt = (PW+1)'(prod3_r) + HalfRange;
  assign th_nxt = sat3_r ? OneQ16 : (lo3_r + rnd_nxt[ShW +: TW]);

  // stage 5: square and activation
  logic            v5_r, cmd5_r;
  logic [2*TW-1:0] sq5_r;
  logic [TW-1:0]   act5_r;
  logic [TW:0]     act_sum_nxt;

  assign act_sum_nxt = neg4_r ? ((TW+1)'(OneQ16) - (TW+1)'(th4_r) + (TW+1)'(1))
                              : ((TW+1)'(OneQ16) + (TW+1)'(th4_r) + (TW+1)'(1));

  // stage 6: select and saturate
  logic [2*TW-1:0] dv_nxt;
  logic [TW-1:0]   y_nxt;

  assign dv_nxt = 34'h1_0000_0000 - sq5_r + 34'h1_0000;
  assign y_nxt = cmd5_r ? TW'(dv_nxt >> 17) : act5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      out_valid <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    cmd1_r <= in_cmd;
    neg1_r <= in_x_in[X_W-1];
    mag1_r <= mag_nxt;

    cmd2_r <= cmd1_r;
    neg2_r <= neg1_r;
    sat2_r <= PosW'(mag1_r) >= Range;
    lo2_r <= rom[k_nxt];
    hi2_r <= rom[k_hi_nxt];
    r2_r <= pos_nxt[ShW-1:0];

    cmd3_r <= cmd2_r;
    neg3_r <= neg2_r;
    sat3_r <= sat2_r;
    lo3_r <= lo2_r;
    prod3_r <= PW'(diff_nxt) * PW'(r2_r);

    cmd4_r <= cmd3_r;
    neg4_r <= neg3_r;
    th4_r <= th_nxt;

    cmd5_r <= cmd4_r;
    sq5_r <= (2*TW)'(th4_r) * (2*TW)'(th4_r);
    act5_r <= act_sum_nxt[TW:1];

    out_y_out <= y_nxt[TW-1] ? Y_MAX : y_nxt[Y_W-1:0];
  end

endmodule

`default_nettype wire

FILE: rtl/core/tsa_checker.sv
// ----------------------------------------------------------------------------
// tsa_checker
// Port-level checks for tanh_sigmoid_activation, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module tsa_checker (
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    start,
  input wire logic                    busy,
  input wire logic                    in_cmd,
  input wire logic [tsa_pkg::X_W-1:0] in_x_in,
  input wire logic                    out_valid,
  input wire logic [tsa_pkg::Y_W-1:0] out_y_out
);
  import tsa_pkg::*;

  logic req;
  assign req = start && !busy;

  a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
    req |-> ##PIPE_DEPTH out_valid)
    else $error("request without result after pipeline latency");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(req, PIPE_DEPTH))
    else $error("result strobe without matching request");

  a_deriv_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (req && in_cmd) |-> ##PIPE_DEPTH (out_y_out <= Y_HALF))
    else $error("derivative above one half");

  a_act_neg: assert property (@(posedge clk) disable iff (!rst_n)
    (req && !in_cmd && in_x_in[X_W-1]) |-> ##PIPE_DEPTH (out_y_out <= Y_HALF))
    else $error("activation of negative input above one half");

  a_act_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (req && !in_cmd && !in_x_in[X_W-1]) |-> ##PIPE_DEPTH (out_y_out >= Y_HALF))
    else $error("activation of non-negative input below one half");

endmodule

bind tanh_sigmoid_activation tsa_checker u_tsa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_cmd    (in_cmd),
  .in_x_in   (in_x_in),
  .out_valid (out_valid),
  .out_y_out (out_y_out)
);

`default_nettype wire

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb: scaled tanh activation / derivative pipeline
// Sends signed Q4.12 requests with both commands: first directed edge values,
// then random values that bunch up near segment joints, zero and the clamp
// range, under three sender idle patterns. A scoreboard rebuilds the tanh
// table with the same integer exponential procedure as the block. It predicts
// each Q0.16 result and checks results in request order.
// ----------------------------------------------------------------------------

typedef enum logic {
  CMD_ACT   = 1'b0,
  CMD_DERIV = 1'b1
} act_cmd_t;

class tanh_act_scoreboard;
  localparam int SEGS = tsa_pkg::DEF_TABLE_SEGMENTS;
  localparam int FRAC = tsa_pkg::DEF_INPUT_FRAC_BITS;
  localparam longint unsigned ONE_Q16 = 64'd65536;

  int unsigned tanh_q16[SEGS+1];
  logic [tsa_pkg::Y_W-1:0] expected_y[$];
  int failures;
  int n_requests;
  int n_checked;
  int n_deriv;
  int n_clamped;

  function new();
    longint unsigned u, one, num, den;
    one = 64'd1 << 32;
    for (int k = 0; k <= SEGS; k++) begin
      u = exp_neg(k);
      num = (one - u) << 16;
      den = one + u;
      tanh_q16[k] = int'((num + den / 2) / den);
    end
    failures = 0;
    n_requests = 0;
    n_checked = 0;
    n_deriv = 0;
    n_clamped = 0;
  endfunction

  // exp(-16k/S) in Q0.32: series for exp(g), inverted, then squared five times
  function longint unsigned exp_neg(int k);
    longint unsigned g, term, sum, u;
    g = (longint'(k) << 31) / longint'(SEGS);
    term = 64'd1 << 32;
    sum = term;
    for (int i = 1; i <= 24; i++) begin
      term = ((term * g) >> 32) / longint'(i);
      sum += term;
    end
    u = 64'hFFFF_FFFF_FFFF_FFFF / sum;
    for (int i = 0; i < 5; i++) u = (u * u) >> 32;
    return u;
  endfunction

  function longint unsigned tanh_of_mag(longint unsigned m);
    longint unsigned span, pos, k, r, lo, hi;
    span = longint'(8) << FRAC;
    if (m >= span) return ONE_Q16;
    pos = m * SEGS;
    k = pos / span;
    r = pos % span;
    if (k >= SEGS) return tanh_q16[SEGS];
    lo = tanh_q16[k];
    hi = tanh_q16[k+1];
    if (hi < lo) hi = lo;
    return lo + ((hi - lo) * r + span / 2) / span;
  endfunction

  function logic [tsa_pkg::Y_W-1:0] predict_y(act_cmd_t c, logic [tsa_pkg::X_W-1:0] x);
    bit neg;
    longint unsigned mag, th, y;
    neg = x[tsa_pkg::X_W-1];
    mag = neg ? (64'h10000 - longint'(x)) : longint'(x);
    th = tanh_of_mag(mag);
    if (c == CMD_ACT) begin
      y = ((neg ? (ONE_Q16 - th) : (ONE_Q16 + th)) + 1) >> 1;
    end else begin
      y = (((64'd1 << 32) - th * th) + (64'd1 << 16)) >> 17;
    end
    if (y > 64'd65535) y = 64'd65535;
    return y[tsa_pkg::Y_W-1:0];
  endfunction

  function void note_request(act_cmd_t c, logic [tsa_pkg::X_W-1:0] x);
    expected_y = {expected_y, predict_y(c, x)};
    n_requests++;
    if (c == CMD_DERIV) n_deriv++;
    if (x == 16'h8000) n_clamped++;
  endfunction

  function void check_result(logic [tsa_pkg::Y_W-1:0] y);
    logic [tsa_pkg::Y_W-1:0] want;
    if (expected_y.size() == 0) begin
      $display("%0t: unexpected result y_out=%0d", $time, y);
      failures++;
      return;
    end
    want = expected_y.pop_front();
    n_checked++;
    if (y !== want) begin
      $display("%0t: y_out mismatch: expected %0d actual %0d", $time, want, y);
      failures++;
    end
  endfunction

  function int pending();
    return expected_y.size();
  endfunction

  function void finish_check();
    if (expected_y.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_y.size());
      failures++;
    end
  endfunction
endclass

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  logic in_cmd;
  logic [tsa_pkg::X_W-1:0] in_x_in;
  logic out_valid;
  logic [tsa_pkg::Y_W-1:0] out_y_out;

  int idle_pct;
  tanh_act_scoreboard sb = new();

  always #5ns clk = ~clk;

  tanh_sigmoid_activation dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_cmd    (in_cmd),
    .in_x_in   (in_x_in),
    .out_valid (out_valid),
    .out_y_out (out_y_out)
  );

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_request(act_cmd_t'(in_cmd), in_x_in);
      if (out_valid) sb.check_result(out_y_out);
    end
  end

  // returns right after the edge that took the request
  task automatic send_request(input act_cmd_t c, input logic [tsa_pkg::X_W-1:0] x);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_cmd <= c;
    in_x_in <= x;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic send_both(input logic [tsa_pkg::X_W-1:0] x);
    send_request(CMD_ACT, x);
    send_request(CMD_DERIV, x);
  endtask

  function automatic logic [tsa_pkg::X_W-1:0] random_x();
    int sel;
    logic [tsa_pkg::X_W-1:0] v;
    sel = $urandom_range(99);
    if (sel < 40) begin
      v = $urandom;
    end else if (sel < 60) begin
      v = 16'($urandom_range(2048)) - 16'd1024;
    end else if (sel < 80) begin
      // near a segment joint, either sign
      v = 16'($urandom_range(63) * 512) + 16'($urandom_range(6)) - 16'd3;
      if ($urandom_range(1)) v = -v;
    end else if (sel < 90) begin
      case ($urandom_range(3))
        0: v = 16'h8000;
        1: v = 16'h7FFF;
        2: v = 16'h8001;
        default: v = 16'h8000 + 16'($urandom_range(255));
      endcase
    end else begin
      v = 16'($urandom_range(16)) - 16'd8;
    end
    return v;
  endfunction

  task automatic random_phase(input int pct, input int count);
    idle_pct = pct;
    for (int i = 0; i < count; i++) begin
      send_request(act_cmd_t'($urandom_range(1)), random_x());
    end
  endtask

  initial begin
    int waited;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_cmd <= CMD_ACT;
    in_x_in <= '0;
    idle_pct = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero, smallest steps, segment joints, top of table, clamp
    send_both(16'h0000);
    send_both(16'h0001);
    send_both(16'hFFFF);
    send_both(16'd511);
    send_both(16'd512);
    send_both(-16'sd512);
    send_both(16'd32256);
    send_both(16'h7FFF);
    send_both(16'h8001);
    send_both(16'h8000);
    send_both(16'd4096);
    send_both(16'hAAAA);

    random_phase(30, 200);
    random_phase(49, 200);
    random_phase(0, 200);
    start <= 1'b0;

    waited = 0;
    while (sb.pending() != 0 && waited < 1000) begin
      @(posedge clk);
      waited++;
    end
    repeat (tsa_pkg::PIPE_DEPTH + 4) @(posedge clk);
    sb.finish_check();

    $display("Sent %0d requests (%0d derivative, %0d at the clamp value), checked %0d results.",
             sb.n_requests, sb.n_deriv, sb.n_clamped, sb.n_checked);
    if (sb.failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #1ms;
    $display("Timeout: run did not complete");
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
